[rtl/rdno_pkg.sv]
// ============================================================================
// rdno_pkg: shared types, constants and tables for the recurring date block
// Holds the date layout, rule codes, calendar tables and the fixed-point
// reciprocals used to divide by constants.
// ============================================================================
`default_nettype none

package rdno_pkg;

    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int RULE_W = 2;

    // Widths of the day-serial arithmetic. Serials count from a point one era
    // before year zero, so every term is non-negative.
    localparam int Z_W   = 22;
    localparam int ERA_W = 5;
    localparam int DOE_W = 18;
    localparam int YOE_W = 9;
    localparam int DOY_W = 9;
    localparam int MP_W  = 4;
    localparam int Q100_W = 7;
    localparam int Q7_W   = 20;

    localparam int ERA_MAX = 26;

    localparam int SER_LAT  = 5;
    localparam int CIV_LAT  = 8;
    localparam int PIPE_LAT = 4 + SER_LAT + 3 + CIV_LAT + 1;

    localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'd9999;
    localparam logic [YEAR_W-1:0] YEAR_LIMIT  = 14'd10000;
    localparam logic [YEAR_W-1:0] YEAR_SHIFT  = 14'd400;
    localparam logic [MON_W-1:0]  MON_MAX     = 4'd12;
    localparam logic [Z_W-1:0]    ERA_DAYS    = 22'd146097;

    // Reciprocals: floor(x / D) == (x * RECIP) >> SHIFT over the ranges used.
    localparam logic [14:0] RECIP100  = 15'd20972;    // shift 21, x < 2**14
    localparam logic [14:0] RECIP400  = 15'd20972;    // shift 23, x < 2**14
    localparam logic [18:0] RECIP1460 = 19'd367720;   // shift 29, x < 146097
    localparam logic [20:0] RECIP365  = 21'd1470880;  // shift 29, x < 146097
    localparam logic [11:0] RECIP153  = 12'd3427;     // shift 19, x < 2048
    localparam logic [22:0] RECIP7    = 23'd4793491;  // shift 25, x < 2**22

    typedef enum logic [RULE_W-1:0] {
        RULE_NEVER   = 2'd0,
        RULE_WEEKLY  = 2'd1,
        RULE_MONTHLY = 2'd2,
        RULE_YEARLY  = 2'd3
    } rule_t;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
    } date_t;

    // Days from March 1 to the first day of month index mi (March is zero).
    function automatic logic [DOY_W-1:0] doy_base(input logic [MP_W-1:0] mi);
        logic [DOY_W-1:0] r;
        case (mi)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:                 r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            default:              r = 5'd31;
        endcase
        return r;
    endfunction

    // Number of whole centuries in a year of era.
    function automatic logic [1:0] cent_of(input logic [YOE_W-1:0] yoe);
        logic [1:0] r;
        if (yoe >= 9'd300)
            r = 2'd3;
        else if (yoe >= 9'd200)
            r = 2'd2;
        else if (yoe >= 9'd100)
            r = 2'd1;
        else
            r = 2'd0;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/recurring_date_next_occurrence.sv]
// ============================================================================
// recurring_date_next_occurrence: next occurrence of a recurring date
// Returns the first occurrence of an anchor date on or after today for
// never, weekly, monthly and yearly repeat rules.
// ============================================================================
// A query is taken on every cycle in which start is high; busy is always low.
// Each query gives exactly one result, shown on next_year, next_month and
// next_day for one cycle with done high. The pipeline has four stages of input
// conditioning and month-end clamping, five for the date-to-serial converters,
// three for the weekly difference and week rounding, eight for the
// serial-to-date converter and then the output register. Results come out in
// query order and must be taken when shown. Out-of-range inputs are clamped:
// years above 9999 to 9999, month zero to January, months above 12 to
// December, day zero to the first.
`default_nettype none

module recurring_date_next_occurrence
    import rdno_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [YEAR_W-1:0] anchor_year,
    input  wire logic [MON_W-1:0]  anchor_month,
    input  wire logic [DAY_W-1:0]  anchor_day,
    input  wire logic [RULE_W-1:0] repeat_rule,
    input  wire logic [YEAR_W-1:0] today_year,
    input  wire logic [MON_W-1:0]  today_month,
    input  wire logic [DAY_W-1:0]  today_day,
    output logic                   done,
    output logic [YEAR_W-1:0]      next_year,
    output logic [MON_W-1:0]       next_month,
    output logic [DAY_W-1:0]       next_day
);

    typedef struct packed {
        date_t a;
        date_t t;
        rule_t rule;
    } query_t;

    typedef struct packed {
        query_t            q;
        logic [YEAR_W-1:0] c1y;
        logic [MON_W-1:0]  c1m;
        logic [YEAR_W-1:0] c2y;
        logic [MON_W-1:0]  c2m;
    } cand_t;

    typedef struct packed {
        cand_t             c;
        logic [Q100_W-1:0] q1;
        logic [Q100_W-1:0] q2;
    } cent_t;

    typedef struct packed {
        query_t q;
        date_t  c1;
        date_t  c2;
    } fit_t;

    typedef struct packed {
        date_t          a;
        rule_t          rule;
        date_t          res;
        logic           pos;
        logic [Z_W-1:0] zt;
        logic [Z_W-1:0] diff;
    } cmp_t;

    typedef struct packed {
        date_t a;
        rule_t rule;
        date_t res;
        logic  pos;
    } side_t;

    logic   accept;
    query_t s1_reg, s1_next;
    cand_t  s2_reg, s2_next;
    cent_t  s3_reg, s3_next;
    fit_t   s4_reg, s4_next;
    fit_t   sdly_reg [SER_LAT];
    cmp_t   s10_reg, s10_next;
    cmp_t   s11_reg;
    logic [Q7_W-1:0] q7_reg, q7_next;
    side_t  s12_reg, s12_next;
    logic [Z_W-1:0] zr_reg, zr_next;
    side_t  cdly_reg [CIV_LAT];
    date_t  out_reg, out_next;

    logic [3:0]           v_reg, v_next;
    logic [SER_LAT-1:0]   vs_reg;
    logic [2:0]           vw_reg;
    logic [CIV_LAT-1:0]   vc_reg;
    logic                 done_reg;

    logic [Z_W-1:0] zt, za, zc;
    date_t          civ;
    logic [28:0]    pq1, pq2;
    logic [44:0]    p7;
    logic [Z_W-1:0] r7_full;
    logic [2:0]     r7;
    logic [YEAR_W-1:0] rem1, rem2;
    logic           leap1, leap2;
    logic [DAY_W-1:0] len1, len2;
    logic           mon_later;
    fit_t           sd;
    side_t          cd;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        // Stage 1: clamp the fields into their legal ranges.
        s1_next.a.year  = (anchor_year > YEAR_MAX) ? YEAR_MAX : anchor_year;
        s1_next.a.month = (anchor_month == 4'd0) ? 4'd1
                        : (anchor_month > MON_MAX) ? MON_MAX : anchor_month;
        s1_next.a.day   = (anchor_day == 5'd0) ? 5'd1 : anchor_day;
        s1_next.t.year  = (today_year > YEAR_MAX) ? YEAR_MAX : today_year;
        s1_next.t.month = (today_month == 4'd0) ? 4'd1
                        : (today_month > MON_MAX) ? MON_MAX : today_month;
        s1_next.t.day   = (today_day == 5'd0) ? 5'd1 : today_day;
        s1_next.rule    = rule_t'(repeat_rule);

        // Stage 2: first and second candidate year and month.
        s2_next.q = s1_reg;
        mon_later = {s1_reg.t.year, s1_reg.t.month} > {s1_reg.a.year, s1_reg.a.month};
        if (s1_reg.rule == RULE_MONTHLY)
        begin
            s2_next.c1y = mon_later ? s1_reg.t.year : s1_reg.a.year;
            s2_next.c1m = mon_later ? s1_reg.t.month : s1_reg.a.month;
            if (s2_next.c1m == MON_MAX)
            begin
                s2_next.c2y = s2_next.c1y + 14'd1;
                s2_next.c2m = 4'd1;
            end
            else
            begin
                s2_next.c2y = s2_next.c1y;
                s2_next.c2m = s2_next.c1m + 4'd1;
            end
        end
        else
        begin
            s2_next.c1y = (s1_reg.t.year > s1_reg.a.year) ? s1_reg.t.year : s1_reg.a.year;
            s2_next.c1m = s1_reg.a.month;
            s2_next.c2y = s2_next.c1y + 14'd1;
            s2_next.c2m = s1_reg.a.month;
        end

        // Stage 3: centuries of both candidate years.
        s3_next.c = s2_reg;
        pq1 = 29'(s2_reg.c1y) * 29'(RECIP100);
        pq2 = 29'(s2_reg.c2y) * 29'(RECIP100);
        s3_next.q1 = pq1[27:21];
        s3_next.q2 = pq2[27:21];

        // Stage 4: leap years and the day clamped to the month length.
        rem1 = s3_reg.c.c1y - 14'(s3_reg.q1) * 14'd100;
        rem2 = s3_reg.c.c2y - 14'(s3_reg.q2) * 14'd100;
        leap1 = (s3_reg.c.c1y[1:0] == 2'd0 && rem1 != '0)
             || (rem1 == '0 && s3_reg.q1[1:0] == 2'd0);
        leap2 = (s3_reg.c.c2y[1:0] == 2'd0 && rem2 != '0)
             || (rem2 == '0 && s3_reg.q2[1:0] == 2'd0);
        len1 = month_len(s3_reg.c.c1m, leap1);
        len2 = month_len(s3_reg.c.c2m, leap2);
        s4_next.q = s3_reg.c.q;
        s4_next.c1.year  = s3_reg.c.c1y;
        s4_next.c1.month = s3_reg.c.c1m;
        s4_next.c1.day   = (s3_reg.c.q.a.day > len1) ? len1 : s3_reg.c.q.a.day;
        s4_next.c2.year  = s3_reg.c.c2y;
        s4_next.c2.month = s3_reg.c.c2m;
        s4_next.c2.day   = (s3_reg.c.q.a.day > len2) ? len2 : s3_reg.c.q.a.day;

        // Stage after the serials: pick the month or year candidate and
        // form the weekly day difference.
        sd = sdly_reg[SER_LAT-1];
        s10_next.a    = sd.q.a;
        s10_next.rule = sd.q.rule;
        s10_next.res  = (zc < zt) ? sd.c2 : sd.c1;
        s10_next.pos  = zt > za;
        s10_next.zt   = zt;
        s10_next.diff = zt - za;

        p7 = 45'(s10_reg.diff) * 45'(RECIP7);
        q7_next = p7[44:25];

        // Round the difference up to whole weeks from today.
        r7_full = s11_reg.diff - 22'(q7_reg) * 22'd7;
        r7 = r7_full[2:0];
        zr_next = s11_reg.zt + ((r7 == 3'd0) ? 22'd0 : 22'(3'd7 - r7));
        s12_next.a    = s11_reg.a;
        s12_next.rule = s11_reg.rule;
        s12_next.res  = s11_reg.res;
        s12_next.pos  = s11_reg.pos;

        cd = cdly_reg[CIV_LAT-1];
        case (cd.rule)
            RULE_WEEKLY:  out_next = cd.pos ? civ : cd.a;
            RULE_MONTHLY: out_next = cd.res;
            RULE_YEARLY:  out_next = cd.res;
            default:      out_next = cd.a;
        endcase
    end

    rdno_serial u_ser_today (.clk(clk), .date(s4_reg.q.t), .z(zt));
    rdno_serial u_ser_anchor (.clk(clk), .date(s4_reg.q.a), .z(za));
    rdno_serial u_ser_cand (.clk(clk), .date(s4_reg.c1), .z(zc));
    rdno_civil  u_civil (.clk(clk), .z(zr_reg), .date(civ));

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        s2_reg  <= s2_next;
        s3_reg  <= s3_next;
        s4_reg  <= s4_next;
        sdly_reg[0] <= s4_reg;
        for (int i = 1; i < SER_LAT; i++)
            sdly_reg[i] <= sdly_reg[i-1];
        s10_reg <= s10_next;
        s11_reg <= s10_reg;
        q7_reg  <= q7_next;
        s12_reg <= s12_next;
        zr_reg  <= zr_next;
        cdly_reg[0] <= s12_reg;
        for (int i = 1; i < CIV_LAT; i++)
            cdly_reg[i] <= cdly_reg[i-1];
        out_reg <= out_next;
    end

    assign v_next = {v_reg[2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            vs_reg   <= '0;
            vw_reg   <= '0;
            vc_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= v_next;
            vs_reg   <= {vs_reg[SER_LAT-2:0], v_reg[3]};
            vw_reg   <= {vw_reg[1:0], vs_reg[SER_LAT-1]};
            vc_reg   <= {vc_reg[CIV_LAT-2:0], vw_reg[2]};
            done_reg <= vc_reg[CIV_LAT-1];
        end
    end

    assign done       = done_reg;
    assign next_year  = out_reg.year;
    assign next_month = out_reg.month;
    assign next_day   = out_reg.day;

endmodule

`default_nettype wire

[rtl/rdno_serial.sv]
// ============================================================================
// rdno_serial: civil date to day serial
// Five register stages: year shift, era split, year of era, day of era and
// the final serial. One date enters every cycle.
// ============================================================================
`default_nettype none

module rdno_serial
    import rdno_pkg::*;
(
    input  wire logic           clk,
    input  wire date_t          date,
    output logic [Z_W-1:0]      z
);

    logic [YEAR_W-1:0] yy1_reg, yy1_next, yy2_reg;
    logic [DOY_W-1:0]  doy1_reg, doy1_next, doy2_reg, doy3_reg;
    logic [MP_W-1:0]   mi;
    logic [28:0]       era_prod;
    logic [ERA_W-1:0]  era2_reg, era2_next, era3_reg, era4_reg;
    logic [YOE_W-1:0]  yoe3_reg, yoe3_next;
    logic [DOE_W-1:0]  doe4_reg, doe4_next;
    logic [Z_W-1:0]    z5_reg, z5_next;

    always_comb
    begin
        mi = (date.month > 4'd2) ? date.month - 4'd3 : date.month + 4'd9;
        yy1_next = date.year + YEAR_SHIFT - ((date.month <= 4'd2) ? 14'd1 : 14'd0);
        doy1_next = doy_base(mi) + DOY_W'(date.day) - 9'd1;

        era_prod = 29'(yy1_reg) * 29'(RECIP400);
        era2_next = era_prod[27:23];

        yoe3_next = YOE_W'(yy2_reg - 14'(era2_reg) * 14'd400);

        doe4_next = 18'(yoe3_reg) * 18'd365 + 18'(yoe3_reg >> 2)
                    - 18'(cent_of(yoe3_reg)) + 18'(doy3_reg);

        z5_next = 22'(era4_reg) * ERA_DAYS + 22'(doe4_reg);
    end

    always_ff @(posedge clk)
    begin
        yy1_reg  <= yy1_next;
        doy1_reg <= doy1_next;
        era2_reg <= era2_next;
        yy2_reg  <= yy1_reg;
        doy2_reg <= doy1_reg;
        era3_reg <= era2_reg;
        yoe3_reg <= yoe3_next;
        doy3_reg <= doy2_reg;
        era4_reg <= era3_reg;
        doe4_reg <= doe4_next;
        z5_reg   <= z5_next;
    end

    assign z = z5_reg;

endmodule

`default_nettype wire

[rtl/rdno_civil.sv]
// ============================================================================
// rdno_civil: day serial to civil date
// Eight register stages: era count, day of era, century and leap corrections,
// year of era, day of year, month and the final date.
// ============================================================================
`default_nettype none

module rdno_civil
    import rdno_pkg::*;
(
    input  wire logic           clk,
    input  wire logic [Z_W-1:0] z,
    output date_t               date
);

    logic [ERA_W-1:0] era1_reg, era1_next, era2_reg, era3_reg, era4_reg;
    logic [ERA_W-1:0] era5_reg, era6_reg, era7_reg;
    logic [Z_W-1:0]   z1_reg;
    logic [DOE_W-1:0] doe2_reg, doe2_next, doe3_reg, doe4_reg, doe5_reg;
    logic [36:0]      p1;
    logic [Q100_W-1:0] q3_reg, q3_next;
    logic [1:0]       cnt3_reg, cnt3_next;
    logic [DOE_W-1:0] n4_reg, n4_next;
    logic [38:0]      p2;
    logic [YOE_W-1:0] yoe5_reg, yoe5_next, yoe6_reg, yoe7_reg;
    logic [DOY_W-1:0] doy6_reg, doy6_next, doy7_reg;
    logic [DOE_W-1:0] doy_sub;
    logic [10:0]      mp_arg;
    logic [22:0]      p3;
    logic [MP_W-1:0]  mp7_reg, mp7_next;
    logic [MON_W-1:0] mm;
    logic [14:0]      yr;
    date_t            out_reg, out_next;

    always_comb
    begin
        // The era is small, so it is found by comparing against every boundary.
        era1_next = '0;
        for (int k = 1; k <= ERA_MAX; k++)
        begin
            if (z >= Z_W'(k * 146097))
                era1_next = era1_next + 5'd1;
        end

        doe2_next = DOE_W'(z1_reg - 22'(era1_reg) * ERA_DAYS);

        p1 = 37'(doe2_reg) * 37'(RECIP1460);
        q3_next = p1[35:29];
        cnt3_next = 2'((doe2_reg >= 18'd36524) ? 1 : 0)
                  + 2'((doe2_reg >= 18'd73048) ? 1 : 0)
                  + 2'((doe2_reg >= 18'd109572) ? 1 : 0);

        n4_next = doe3_reg - 18'(q3_reg) + 18'(cnt3_reg);

        p2 = 39'(n4_reg) * 39'(RECIP365);
        yoe5_next = p2[37:29];

        doy_sub = 18'(yoe5_reg) * 18'd365 + 18'(yoe5_reg >> 2) - 18'(cent_of(yoe5_reg));
        doy6_next = DOY_W'(doe5_reg - doy_sub);

        mp_arg = 11'(doy6_reg) * 11'd5 + 11'd2;
        p3 = 23'(mp_arg) * 23'(RECIP153);
        mp7_next = p3[22:19];

        mm = (mp7_reg < 4'd10) ? mp7_reg + 4'd3 : mp7_reg - 4'd9;
        yr = 15'(era7_reg) * 15'd400 + 15'(yoe7_reg) + ((mm <= 4'd2) ? 15'd1 : 15'd0);
        out_next.year  = (yr >= 15'd400) ? YEAR_W'(yr - 15'd400) : '0;
        out_next.month = mm;
        out_next.day   = DAY_W'(doy7_reg - doy_base(mp7_reg) + 9'd1);
    end

    always_ff @(posedge clk)
    begin
        era1_reg <= era1_next;
        z1_reg   <= z;
        era2_reg <= era1_reg;
        doe2_reg <= doe2_next;
        era3_reg <= era2_reg;
        doe3_reg <= doe2_reg;
        q3_reg   <= q3_next;
        cnt3_reg <= cnt3_next;
        era4_reg <= era3_reg;
        doe4_reg <= doe3_reg;
        n4_reg   <= n4_next;
        era5_reg <= era4_reg;
        doe5_reg <= doe4_reg;
        yoe5_reg <= yoe5_next;
        era6_reg <= era5_reg;
        yoe6_reg <= yoe5_reg;
        doy6_reg <= doy6_next;
        era7_reg <= era6_reg;
        yoe7_reg <= yoe6_reg;
        doy7_reg <= doy6_reg;
        mp7_reg  <= mp7_next;
        out_reg  <= out_next;
    end

    assign date = out_reg;

endmodule

`default_nettype wire

[rtl/rdno_checker.sv]
// ============================================================================
// rdno_checker: port-level checks for the recurring date block
// Watches query transfers and result strobes on the top-level ports.
// ============================================================================
`default_nettype none

module rdno_checker
    import rdno_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire logic [YEAR_W-1:0] next_year,
    input wire logic [MON_W-1:0]  next_month,
    input wire logic [DAY_W-1:0]  next_day
);

    // The block takes a query in every cycle.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every result belongs to a query taken the pipeline latency earlier.
    a_done_has_query: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without a matching query");

    // Every taken query yields its result after the pipeline latency.
    a_query_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("query transfer lost");

    // Results are always a plausible calendar date.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (next_month >= 4'd1 && next_month <= MON_MAX && next_day != 5'd0
                  && next_year <= YEAR_LIMIT))
        else $error("result date out of range");

endmodule

bind recurring_date_next_occurrence rdno_checker u_rdno_checker (.*);

`default_nettype wire

[tb/recurring_date_next_occurrence_tb.sv]
// ============================================================================
// recurring_date_next_occurrence_tb: self-checking bench for the date block
// Drives date queries with random idle bursts, predicts each next occurrence
// with an independent calendar model and checks every strobed result in order.
// ============================================================================
`default_nettype none

module recurring_date_next_occurrence_tb;
    import rdno_pkg::*;

    localparam int LATENCY = PIPE_LAT + 4;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [YEAR_W-1:0] anchor_year;
    logic [MON_W-1:0]  anchor_month;
    logic [DAY_W-1:0]  anchor_day;
    logic [RULE_W-1:0] repeat_rule;
    logic [YEAR_W-1:0] today_year;
    logic [MON_W-1:0]  today_month;
    logic [DAY_W-1:0]  today_day;
    logic              done;
    logic [YEAR_W-1:0] next_year;
    logic [MON_W-1:0]  next_month;
    logic [DAY_W-1:0]  next_day;

    int error_count = 0;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic bit is_leap(input longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint days_in_month(input longint y, input longint m);
        if (m == 2)
            return is_leap(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic longint clamp_day(input longint y, input longint m, input longint d);
        longint lim;
        lim = days_in_month(y, m);
        return (d > lim) ? lim : d;
    endfunction

    // Days counted from a point 400 years before year zero; day may overrun the month.
    function automatic longint day_number(input longint y, input longint m, input longint d);
        longint yy;
        longint mi;
        yy = y + 400 - ((m <= 2) ? 1 : 0);
        mi = (m > 2) ? m - 3 : m + 9;
        return yy * 365 + yy / 4 - yy / 100 + yy / 400 + (153 * mi + 2) / 5 + d - 1;
    endfunction

    function automatic date_t date_of(input longint n);
        longint era;
        longint doe;
        longint yoe;
        longint doy;
        longint mp;
        longint mm;
        longint yr;
        date_t  r;
        era = n / 146097;
        doe = n % 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        mm  = (mp < 10) ? mp + 3 : mp - 9;
        yr  = yoe + era * 400 + ((mm <= 2) ? 1 : 0);
        r.year  = (yr >= 400) ? yr - 400 : 0;
        r.month = mm;
        r.day   = doy - (153 * mp + 2) / 5 + 1;
        return r;
    endfunction

    function automatic date_t next_occurrence(input date_t a, input rule_t rule, input date_t t);
        longint ay, am, ad, ty, tm, td;
        longint tn, an, diff, total;
        date_t  r;
        ay = (a.year > YEAR_MAX) ? YEAR_MAX : a.year;
        am = (a.month == 0) ? 1 : ((a.month > MON_MAX) ? MON_MAX : a.month);
        ad = (a.day == 0) ? 1 : a.day;
        ty = (t.year > YEAR_MAX) ? YEAR_MAX : t.year;
        tm = (t.month == 0) ? 1 : ((t.month > MON_MAX) ? MON_MAX : t.month);
        td = (t.day == 0) ? 1 : t.day;
        tn = day_number(ty, tm, td);
        r.year = ay;
        r.month = am;
        r.day = ad;
        case (rule)
            RULE_WEEKLY:
            begin
                an = day_number(ay, am, ad);
                diff = tn - an;
                if (diff > 0)
                    r = date_of(an + ((diff + 6) / 7) * 7);
            end
            RULE_MONTHLY:
            begin
                total = ay * 12 + am - 1;
                if (ty * 12 + tm - 1 > total)
                    total = ty * 12 + tm - 1;
                if (day_number(total / 12, total % 12 + 1,
                               clamp_day(total / 12, total % 12 + 1, ad)) < tn)
                    total++;
                r.year = total / 12;
                r.month = total % 12 + 1;
                r.day = clamp_day(total / 12, total % 12 + 1, ad);
            end
            RULE_YEARLY:
            begin
                total = (ty > ay) ? ty : ay;
                if (day_number(total, am, clamp_day(total, am, ad)) < tn)
                    total++;
                r.year = total;
                r.day = clamp_day(total, am, ad);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    class date_scoreboard;
        date_t pending[$];

        function void note_query(input date_t a, input rule_t rule, input date_t t);
            pending.push_back(next_occurrence(a, rule, t));
        endfunction

        task check_result(input date_t got);
            date_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %0d-%0d-%0d",
                                          got.year, got.month, got.day));
                return;
            end
            want = pending.pop_front();
            if (got.year !== want.year)
                report_mismatch($sformatf("next_year %0d, want %0d", got.year, want.year));
            if (got.month !== want.month)
                report_mismatch($sformatf("next_month %0d, want %0d", got.month, want.month));
            if (got.day !== want.day)
                report_mismatch($sformatf("next_day %0d, want %0d", got.day, want.day));
        endtask
    endclass

    date_scoreboard scoreboard = new();
    bit allow_idle = 1;

    recurring_date_next_occurrence i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .anchor_year (anchor_year),
        .anchor_month(anchor_month),
        .anchor_day  (anchor_day),
        .repeat_rule (repeat_rule),
        .today_year  (today_year),
        .today_month (today_month),
        .today_day   (today_day),
        .done        (done),
        .next_year   (next_year),
        .next_month  (next_month),
        .next_day    (next_day)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            scoreboard.check_result('{year: next_year, month: next_month, day: next_day});
    end

    // Presents one query and holds it until the transfer happens.
    task automatic send_query(input date_t a, input rule_t rule, input date_t t);
        if (allow_idle && $urandom_range(0, 7) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start        <= 1'b1;
        anchor_year  <= a.year;
        anchor_month <= a.month;
        anchor_day   <= a.day;
        repeat_rule  <= rule;
        today_year   <= t.year;
        today_month  <= t.month;
        today_day    <= t.day;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        scoreboard.note_query(a, rule, t);
    endtask

    function automatic date_t random_date(input bit wild);
        date_t d;
        if (wild)
        begin
            d.year  = $urandom;
            d.month = $urandom;
            d.day   = $urandom;
        end
        else
        begin
            d.year  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9999)
                                                  : $urandom_range(1900, 2100);
            d.month = $urandom_range(1, 12);
            d.day   = $urandom_range(1, 31);
        end
        return d;
    endfunction

    // Keeps today near the anchor most of the time so all branches get hit.
    function automatic date_t near_date(input date_t a);
        date_t d;
        int    dy;
        d = random_date(1'b0);
        dy = $urandom_range(0, 6) - 2;
        if (int'(a.year) + dy >= 0 && int'(a.year) + dy <= 9999)
            d.year = int'(a.year) + dy;
        return d;
    endfunction

    initial
    begin
        date_t a;
        date_t t;
        rule_t rule;
        start        <= 1'b0;
        anchor_year  <= '0;
        anchor_month <= '0;
        anchor_day   <= '0;
        repeat_rule  <= '0;
        today_year   <= '0;
        today_month  <= '0;
        today_day    <= '0;
        rst_n        <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every rule, clamping, month ends and year 10000.
        for (int r = 0; r < 4; r++)
        begin
            rule = rule_t'(r);
            send_query('{year: 9999, month: 12, day: 31}, rule, '{year: 9999, month: 12, day: 31});
            send_query('{year: 0, month: 0, day: 0}, rule, '{year: 16383, month: 15, day: 31});
            send_query('{year: 2024, month: 1, day: 31}, rule, '{year: 2024, month: 2, day: 5});
            send_query('{year: 9999, month: 2, day: 29}, rule, '{year: 9999, month: 3, day: 1});
            send_query('{year: 2000, month: 2, day: 31}, rule, '{year: 1999, month: 1, day: 1});
        end
        send_query('{year: 16383, month: 15, day: 31}, RULE_WEEKLY,
                   '{year: 0, month: 0, day: 0});
        send_query('{year: 9999, month: 12, day: 28}, RULE_WEEKLY,
                   '{year: 9999, month: 12, day: 31});

        for (int i = 0; i < 1700; i++)
        begin
            if (i == 800)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (scoreboard.pending.size() != 0)
                    @(posedge clk);
            end
            if (i == 1500)
                allow_idle = 0;
            a = random_date($urandom_range(0, 9) == 0);
            t = ($urandom_range(0, 9) == 0) ? random_date(1'b1) : near_date(a);
            send_query(a, rule_t'($urandom_range(0, 3)), t);
        end
        start <= 1'b0;

        while (scoreboard.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (error_count == 0 && scoreboard.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #500000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/rdno_pkg.sv
rtl/rdno_serial.sv
rtl/rdno_civil.sv
rtl/recurring_date_next_occurrence.sv
rtl/rdno_checker.sv
tb/recurring_date_next_occurrence_tb.sv
